### rtl/core/assert_macros.svh
// assertion helpers shared by the front end and the job queue
// each macro expects clk_i in scope, and CDRT_ASSERT also rst_ni
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define CDRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked at every edge, reset included
`define CDRT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/core/cdrt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdrt_pkg
// Types and constants of the cell draw dirty rectangle tracker.
// ----------------------------------------------------------------------------
package cdrt_pkg;

  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_SHOW = 1'b1;

  localparam logic KIND_GLYPH = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam logic [7:0] LEVEL_FULL = 8'hFF;
  localparam logic [7:0] LEVEL_DIM  = 8'hAF;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLUMNS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_LINES   = 2'd3;
  localparam int unsigned CFG_DATA_W = 9;

  // wide enough for the largest column or line limit
  localparam int unsigned LIM_W = 13;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned M_TDATA_W = 128;

  // one classified command waiting for execution
  typedef struct packed {
    logic        kind;
    logic [7:0]  pos_x;   // column, or left column of the rectangle
    logic [7:0]  pos_y;   // row, or top row of the rectangle
    logic [8:0]  span_x;  // rectangle width in cells, zero for a glyph
    logic [8:0]  span_y;  // rectangle height in cells, zero for a glyph
    logic [2:0]  fg;
    logic [2:0]  bg;
    logic        bold;
    logic [20:0] code;
  } cdrt_job_t;

  function automatic logic [7:0] color_level(input logic on, input logic bold);
    logic [7:0] lvl;
    lvl = 8'd0;
    if (on) begin
      lvl = bold ? LEVEL_FULL : LEVEL_DIM;
    end
    return lvl;
  endfunction

endpackage
`default_nettype wire

### rtl/core/cdrt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdrt_front
// Accepts commands, tracks the dirty rectangle and queues the work.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdrt_front import cdrt_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [LIM_W-1:0] num_columns_i,
  input  wire logic [LIM_W-1:0] num_lines_i,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // column, row, fore_color, back_color, reverse, bold, char_code, zero pad
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  // cmd
  input  wire logic [0:0]       s_axis_tuser,
  input  wire logic             full_i,
  output logic                  push_o,
  output cdrt_job_t             job_o
);

  logic       dirty_q, dirty_d;
  logic [7:0] left_q, left_d, right_q, right_d;
  logic [7:0] top_q, top_d, bottom_q, bottom_d;

  logic        accept;
  logic        cmd;
  logic [7:0]  col, row;
  logic [2:0]  fore, back;
  logic        rev;
  logic        in_range;

  assign s_axis_tready = !full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign cmd  = s_axis_tuser[0];
  assign col  = s_axis_tdata[7:0];
  assign row  = s_axis_tdata[15:8];
  assign fore = s_axis_tdata[18:16];
  assign back = s_axis_tdata[21:19];
  assign rev  = s_axis_tdata[22];

  assign in_range = (LIM_W'(col) < num_columns_i) && (LIM_W'(row) < num_lines_i);

  always_comb begin
    dirty_d  = dirty_q;
    left_d   = left_q;
    right_d  = right_q;
    top_d    = top_q;
    bottom_d = bottom_q;
    push_o   = 1'b0;

    job_o        = '0;
    job_o.kind   = KIND_GLYPH;
    job_o.pos_x  = col;
    job_o.pos_y  = row;
    job_o.fg     = rev ? back : fore;
    job_o.bg     = rev ? fore : back;
    job_o.bold   = s_axis_tdata[23];
    job_o.code   = s_axis_tdata[44:24];

    if (accept) begin
      case (cmd)
        CMD_DRAW: begin
          if (in_range) begin
            push_o  = 1'b1;
            dirty_d = 1'b1;
            if (!dirty_q) begin
              left_d   = col;
              right_d  = col;
              top_d    = row;
              bottom_d = row;
            end else begin
              if (col < left_q)   left_d   = col;
              if (col > right_q)  right_d  = col;
              if (row < top_q)    top_d    = row;
              if (row > bottom_q) bottom_d = row;
            end
          end
        end
        CMD_SHOW: begin
          if (dirty_q) begin
            push_o       = 1'b1;
            job_o        = '0;
            job_o.kind   = KIND_FLUSH;
            job_o.pos_x  = left_q;
            job_o.pos_y  = top_q;
            job_o.span_x = 9'(right_q - left_q) + 9'd1;
            job_o.span_y = 9'(bottom_q - top_q) + 9'd1;
            dirty_d  = 1'b0;
            left_d   = '0;
            right_d  = '0;
            top_d    = '0;
            bottom_d = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirty_q  <= 1'b0;
      left_q   <= '0;
      right_q  <= '0;
      top_q    <= '0;
      bottom_q <= '0;
    end else begin
      dirty_q  <= dirty_d;
      left_q   <= left_d;
      right_q  <= right_d;
      top_q    <= top_d;
      bottom_q <= bottom_d;
    end
  end

  `CDRT_ASSERT(a_rect_ordered, dirty_q |-> (left_q <= right_q && top_q <= bottom_q),
    "dirty rectangle corners out of order")
  `CDRT_ASSERT(a_show_clears, (accept && cmd == CMD_SHOW) |=> !dirty_q,
    "dirty rectangle not cleared by show")
  `CDRT_ASSERT(a_draw_marks, (accept && cmd == CMD_DRAW && in_range) |=> dirty_q,
    "visible draw did not mark the rectangle dirty")

endmodule
`default_nettype wire

### rtl/core/cdrt_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdrt_fifo
// Short job queue between the command front end and the result stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdrt_fifo import cdrt_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  cdrt_job_t      job_i,
  input  wire logic      pop_i,
  output cdrt_job_t      head_o,
  output logic           empty_o,
  output logic           full_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cdrt_job_t        mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign head_o  = mem_q[rd_ptr_q];

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    n = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    return n;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= next_ptr(rd_ptr_q);
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CNT_W'(1);
        2'b01:   count_q <= count_q - CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  `CDRT_ASSERT(a_count_bound, count_q <= CNT_W'(QUEUE_DEPTH),
    "job queue count above depth")
  `CDRT_ASSERT(a_no_overflow, push_i |-> !full_o, "push into full job queue")
  `CDRT_ASSERT(a_no_underflow, pop_i |-> !empty_o, "pop from empty job queue")

endmodule
`default_nettype wire

### rtl/core/cdrt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdrt_back
// Scales queued jobs to pixels, expands colors and holds the result.
// ----------------------------------------------------------------------------
module cdrt_back import cdrt_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [6:0] cell_w_i,
  input  wire logic [6:0] cell_h_i,
  input  cdrt_job_t       head_i,
  input  wire logic       empty_i,
  output logic            pop_o,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  // pix_x, pix_y, rect_w, rect_h, fg_red, fg_green, fg_blue,
  // bg_red, bg_green, bg_blue, glyph_code, zero pad
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // kind
  output logic [0:0]      m_axis_tuser
);

  logic                 valid_q;
  logic [M_TDATA_W-1:0] data_q, data_d;
  logic                 kind_q;

  logic [14:0] px_prod, py_prod;
  logic [15:0] rw_prod, rh_prod;

  assign pop_o = !empty_i && (!valid_q || m_axis_tready);

  assign px_prod = 15'(head_i.pos_x) * 15'(cell_w_i);
  assign py_prod = 15'(head_i.pos_y) * 15'(cell_h_i);
  assign rw_prod = 16'(head_i.span_x) * 16'(cell_w_i);
  assign rh_prod = 16'(head_i.span_y) * 16'(cell_h_i);

  always_comb begin
    data_d           = '0;
    data_d[13:0]     = px_prod[13:0];
    data_d[27:14]    = py_prod[13:0];
    data_d[42:28]    = rw_prod[14:0];
    data_d[57:43]    = rh_prod[14:0];
    data_d[65:58]    = color_level(head_i.fg[0], head_i.bold);
    data_d[73:66]    = color_level(head_i.fg[1], head_i.bold);
    data_d[81:74]    = color_level(head_i.fg[2], head_i.bold);
    data_d[89:82]    = color_level(head_i.bg[0], head_i.bold);
    data_d[97:90]    = color_level(head_i.bg[1], head_i.bold);
    data_d[105:98]   = color_level(head_i.bg[2], head_i.bold);
    data_d[126:106]  = head_i.code;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= data_d;
      kind_q <= head_i.kind;
    end
  end

  assign m_axis_tvalid   = valid_q;
  assign m_axis_tdata    = data_q;
  assign m_axis_tuser[0] = kind_q;

endmodule
`default_nettype wire

### rtl/core/cell_draw_dirty_rect_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cell_draw_dirty_rect_tracker
// Text cell front end: glyph draw requests and dirty rectangle flushes.
// ----------------------------------------------------------------------------
// Takes one command per clock while the job queue is not full. A visible draw
// widens the dirty rectangle and yields a glyph request at the cell's pixel
// position with expanded colors; a show yields the dirty rectangle in pixels
// and clears it. Off-screen draws and shows with nothing dirty are taken and
// give no result. The front end classifies a taken command and writes its job
// into a two-entry job queue; the back end multiplies the queued job by the
// cell size and loads the output register. Throughput is one item per cycle
// while the output side keeps tready high; when it stalls, the output register
// and the two-entry queue hold up to three results before s_axis_tready drops.
// Write the configuration only while the block is idle.
// ----------------------------------------------------------------------------
module cell_draw_dirty_rect_tracker import cdrt_pkg::*; #(
  parameter int unsigned MAX_COLUMNS   = 256,
  parameter int unsigned MAX_LINES     = 256,
  parameter int unsigned MAX_CELL_SIZE = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // column, row, fore_color, back_color, reverse, bold, char_code, zero pad
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
  // cmd
  input  wire logic [0:0]            s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // pix_x, pix_y, rect_w, rect_h, fg_red, fg_green, fg_blue,
  // bg_red, bg_green, bg_blue, glyph_code, zero pad
  output logic [M_TDATA_W-1:0]       m_axis_tdata,
  // kind
  output logic [0:0]                 m_axis_tuser
);

  logic [6:0] cell_width_q, cell_height_q;
  logic [8:0] num_columns_q, num_lines_q;

  logic [6:0]       cw_sat, ch_sat;
  logic [LIM_W-1:0] ncols_sat, nlines_sat;

  cdrt_job_t push_job, head_job;
  logic      push, pop, q_empty, q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_width_q  <= 7'd8;
      cell_height_q <= 7'd16;
      num_columns_q <= 9'd80;
      num_lines_q   <= 9'd25;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CELL_WIDTH:  cell_width_q  <= cfg_data_i[6:0];
        CFG_CELL_HEIGHT: cell_height_q <= cfg_data_i[6:0];
        CFG_NUM_COLUMNS: num_columns_q <= cfg_data_i;
        CFG_NUM_LINES:   num_lines_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // clamp the registers to the build limits
  assign cw_sat = (9'(cell_width_q) > 9'(MAX_CELL_SIZE)) ? 7'(MAX_CELL_SIZE) : cell_width_q;
  assign ch_sat = (9'(cell_height_q) > 9'(MAX_CELL_SIZE)) ? 7'(MAX_CELL_SIZE) : cell_height_q;
  assign ncols_sat  = (LIM_W'(num_columns_q) > LIM_W'(MAX_COLUMNS)) ?
                      LIM_W'(MAX_COLUMNS) : LIM_W'(num_columns_q);
  assign nlines_sat = (LIM_W'(num_lines_q) > LIM_W'(MAX_LINES)) ?
                      LIM_W'(MAX_LINES) : LIM_W'(num_lines_q);

  cdrt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .num_columns_i (ncols_sat),
    .num_lines_i   (nlines_sat),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .full_i        (q_full),
    .push_o        (push),
    .job_o         (push_job)
  );

  cdrt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .head_o  (head_job),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  cdrt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cell_w_i      (cw_sat),
    .cell_h_i      (ch_sat),
    .head_i        (head_job),
    .empty_i       (q_empty),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
`default_nettype wire
